FILE: design/wwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwm_pkg
// Shared types, codes and constants of the winch weight mode controller.
// ----------------------------------------------------------------------------
package wwm_pkg;

  localparam int DefaultAvgCount = 10;

  localparam int SumW  = 20;
  localparam int WgtW  = 17;
  localparam int TickW = 16;
  localparam int CmdW  = 4;
  localparam int ModeW = 3;
  localparam int StatW = 2;
  localparam int HeldW = 4;

  localparam logic signed [SumW-1:0] SumMax = 20'sd524287;
  localparam logic signed [SumW-1:0] SumMin = -20'sd524288;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_SAMPLE  = 4'd0;
  localparam logic [CmdW-1:0] CMD_TICK    = 4'd1;
  localparam logic [CmdW-1:0] CMD_MANUAL  = 4'd2;
  localparam logic [CmdW-1:0] CMD_AUTO    = 4'd3;
  localparam logic [CmdW-1:0] CMD_HOLD    = 4'd4;
  localparam logic [CmdW-1:0] CMD_RELEASE = 4'd5;
  localparam logic [CmdW-1:0] CMD_UP      = 4'd6;
  localparam logic [CmdW-1:0] CMD_DOWN    = 4'd7;
  localparam logic [CmdW-1:0] CMD_STOP    = 4'd8;
  localparam logic [CmdW-1:0] CMD_EXIT    = 4'd9;

  // Mode codes.
  localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
  localparam logic [ModeW-1:0] MODE_AUTO    = 3'd1;
  localparam logic [ModeW-1:0] MODE_RAISE   = 3'd2;
  localparam logic [ModeW-1:0] MODE_SETTLE  = 3'd3;
  localparam logic [ModeW-1:0] MODE_ADJUST  = 3'd4;
  localparam logic [ModeW-1:0] MODE_RELEASE = 3'd5;
  localparam logic [ModeW-1:0] MODE_PULSE   = 3'd6;

  // Status codes.
  localparam logic [StatW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatW-1:0] STAT_READ_ERR = 2'd1;
  localparam logic [StatW-1:0] STAT_RANGE    = 2'd2;
  localparam logic [StatW-1:0] STAT_BUSY     = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_DEADBAND  = 3'd0;
  localparam logic [2:0] REG_HOLD_TH   = 3'd1;
  localparam logic [2:0] REG_REL_TH    = 3'd2;
  localparam logic [2:0] REG_ADJ_TH    = 3'd3;
  localparam logic [2:0] REG_SETTLE    = 3'd4;
  localparam logic [2:0] REG_ADJ_TICKS = 3'd5;
  localparam logic [2:0] REG_MIN_PULSE = 3'd6;
  localparam logic [2:0] REG_MAX_PULSE = 3'd7;

  typedef struct packed {
    logic        [TickW-1:0] auto_deadband;
    logic signed [WgtW-1:0]  raise_limit;
    logic signed [WgtW-1:0]  lower_limit;
    logic signed [WgtW-1:0]  adjust_threshold;
    logic        [TickW-1:0] settle_ticks;
    logic        [TickW-1:0] adjust_ticks;
    logic        [TickW-1:0] min_pulse_ticks;
    logic        [TickW-1:0] max_pulse_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    auto_deadband:     16'd600,
    raise_limit:       -17'sd40,
    lower_limit:       -17'sd100,
    adjust_threshold:  -17'sd200,
    settle_ticks:      16'd600,
    adjust_ticks:      16'd300,
    min_pulse_ticks:   16'd100,
    max_pulse_ticks:   16'd3000
  };

  // Averager view of one item, after the item has been applied.
  typedef struct packed {
    logic                   fresh;
    logic                   read_fail;
    logic signed [WgtW-1:0] avg;
    logic [HeldW-1:0]       held;
  } avg_info_t;

  // Mode controller outputs, after the item has been applied.
  typedef struct packed {
    logic             relay_up;
    logic             relay_down;
    logic [ModeW-1:0] mode;
    logic [StatW-1:0] status;
    logic             done;
  } mode_info_t;

endpackage

FILE: design/wwm_avg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwm_avg
// Sample accumulator and averager: saturating sum, sample count and the
// truncated average, computed by a reciprocal multiply.
// ----------------------------------------------------------------------------
module wwm_avg
  import wwm_pkg::*;
#(
  parameter int AVG_COUNT = DefaultAvgCount
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic                   is_sample,
  input  logic                   sample_ok,
  input  logic signed [WgtW-1:0] weight,
  output avg_info_t              info
);

  localparam int CntW  = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  // Exact floor division of a SumW-bit magnitude by a ceiling reciprocal.
  localparam int RecK  = SumW + $clog2(AVG_COUNT);
  localparam int RecW  = RecK + 1;
  localparam int ProdW = SumW + RecW;
  localparam logic [RecW-1:0] Recip =
    RecW'(((64'd1 << RecK) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
  localparam logic [CntW:0] CountEnd = (CntW + 1)'(AVG_COUNT);

  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic [CntW-1:0]        count_r, count_nxt;
  logic signed [WgtW-1:0] avg_r, avg_nxt;

  logic signed [SumW:0]   sum_wide;
  logic signed [SumW-1:0] sum_sat;
  logic [CntW:0]          count_inc;
  logic                   take;
  logic                   complete;
  logic                   neg;
  logic [SumW-1:0]        mag;
  logic [ProdW-1:0]       prod;
  logic [SumW-1:0]        quot;
  logic signed [WgtW-1:0] avg_calc;

  assign take      = is_sample && sample_ok;
  assign sum_wide  = (SumW + 1)'(sum_r) + (SumW + 1)'(weight);
  assign count_inc = (CntW + 1)'(count_r) + 1'b1;
  assign complete  = take && (count_inc >= CountEnd);

  always_comb begin
    if (sum_wide > (SumW + 1)'(SumMax)) begin
      sum_sat = SumMax;
    end else if (sum_wide < (SumW + 1)'(SumMin)) begin
      sum_sat = SumMin;
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  assign neg  = sum_sat[SumW-1];
  assign mag  = neg ? SumW'(-sum_sat) : SumW'(sum_sat);
  assign prod = ProdW'(mag) * ProdW'(Recip);
  assign quot = SumW'(prod >> RecK);

  // Saturate the quotient to the average range, truncated toward zero.
  always_comb begin
    if (neg) begin
      if (quot > SumW'(65536)) begin
        avg_calc = -17'sd65536;
      end else begin
        avg_calc = WgtW'(-$signed({1'b0, quot}));
      end
    end else begin
      if (quot > SumW'(65535)) begin
        avg_calc = 17'sd65535;
      end else begin
        avg_calc = WgtW'(quot);
      end
    end
  end

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    avg_nxt   = avg_r;
    if (complete) begin
      sum_nxt   = '0;
      count_nxt = '0;
      avg_nxt   = avg_calc;
    end else if (take) begin
      sum_nxt   = sum_sat;
      count_nxt = count_inc[CntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      avg_r   <= '0;
    end else if (fire) begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      avg_r   <= avg_nxt;
    end
  end

  assign info.fresh     = complete;
  assign info.read_fail = is_sample && !sample_ok;
  assign info.avg       = avg_nxt;
  assign info.held      = HeldW'(count_nxt);

endmodule

FILE: design/wwm_mode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwm_mode
// Mode sequencer: auto, hold, release and timed pulse modes, relay drives
// and the tick timer.
// ----------------------------------------------------------------------------
module wwm_mode
  import wwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [CmdW-1:0]   cmd,
  input  logic [TickW-1:0]  pulse_ticks,
  input  cfg_t              cfg,
  input  avg_info_t         avg_info,
  output mode_info_t        info
);

  logic [ModeW-1:0]       mode_r, mode_nxt;
  logic                   up_r, up_nxt;
  logic                   down_r, down_nxt;
  logic [TickW-1:0]       timer_r, timer_nxt;
  logic signed [WgtW-1:0] base_r, base_nxt;
  logic [StatW-1:0]       status;
  logic                   done;

  logic signed [WgtW:0]   delta;
  logic signed [WgtW:0]   band;
  logic [TickW-1:0]       timer_dec;
  logic                   timed_mode;
  logic                   in_range;

  assign delta      = (WgtW + 1)'(avg_info.avg) - (WgtW + 1)'(base_r);
  assign band       = $signed({2'b00, cfg.auto_deadband});
  assign timer_dec  = (timer_r != '0) ? timer_r - 1'b1 : '0;
  assign timed_mode = (mode_r == MODE_SETTLE) || (mode_r == MODE_ADJUST) ||
                      (mode_r == MODE_PULSE);
  assign in_range   = (pulse_ticks >= cfg.min_pulse_ticks) &&
                      (pulse_ticks <= cfg.max_pulse_ticks);

  always_comb begin
    mode_nxt  = mode_r;
    up_nxt    = up_r;
    down_nxt  = down_r;
    timer_nxt = timer_r;
    base_nxt  = base_r;
    status    = STAT_OK;
    done      = 1'b0;
    unique case (cmd)
      CMD_SAMPLE: begin
        if (avg_info.read_fail) begin
          status = STAT_READ_ERR;
        end else if (avg_info.fresh) begin
          if (mode_r == MODE_AUTO) begin
            up_nxt   = (delta > band);
            down_nxt = (delta < -band);
          end else if (mode_r == MODE_RAISE) begin
            if (avg_info.avg > cfg.raise_limit) begin
              up_nxt   = 1'b1;
              down_nxt = 1'b0;
            end else begin
              up_nxt    = 1'b0;
              down_nxt  = 1'b0;
              mode_nxt  = MODE_SETTLE;
              timer_nxt = cfg.settle_ticks;
            end
          end else if (mode_r == MODE_RELEASE) begin
            if (avg_info.avg < cfg.lower_limit) begin
              up_nxt   = 1'b0;
              down_nxt = 1'b1;
            end else begin
              up_nxt    = 1'b0;
              down_nxt  = 1'b0;
              mode_nxt  = MODE_IDLE;
              timer_nxt = '0;
              done      = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (timed_mode) begin
          if (timer_dec != '0) begin
            timer_nxt = timer_dec;
          end else if ((mode_r == MODE_SETTLE) &&
                       (avg_info.avg < cfg.adjust_threshold)) begin
            up_nxt    = 1'b0;
            down_nxt  = 1'b1;
            mode_nxt  = MODE_ADJUST;
            timer_nxt = cfg.adjust_ticks;
          end else begin
            up_nxt    = 1'b0;
            down_nxt  = 1'b0;
            mode_nxt  = MODE_IDLE;
            timer_nxt = '0;
            done      = 1'b1;
          end
        end
      end
      CMD_MANUAL, CMD_EXIT: begin
        up_nxt    = 1'b0;
        down_nxt  = 1'b0;
        mode_nxt  = MODE_IDLE;
        timer_nxt = '0;
        done      = (mode_r != MODE_IDLE);
      end
      CMD_AUTO, CMD_HOLD, CMD_RELEASE, CMD_UP, CMD_DOWN: begin
        if (mode_r != MODE_IDLE) begin
          status = STAT_BUSY;
        end else if (cmd == CMD_AUTO) begin
          // The base equals the average at entry, so both relays start off.
          base_nxt = avg_info.avg;
          mode_nxt = MODE_AUTO;
          up_nxt   = 1'b0;
          down_nxt = 1'b0;
        end else if (cmd == CMD_HOLD) begin
          if (avg_info.avg > cfg.raise_limit) begin
            up_nxt   = 1'b1;
            down_nxt = 1'b0;
            mode_nxt = MODE_RAISE;
          end else begin
            up_nxt    = 1'b0;
            down_nxt  = 1'b0;
            mode_nxt  = MODE_SETTLE;
            timer_nxt = cfg.settle_ticks;
          end
        end else if (cmd == CMD_RELEASE) begin
          if (avg_info.avg < cfg.lower_limit) begin
            up_nxt   = 1'b0;
            down_nxt = 1'b1;
            mode_nxt = MODE_RELEASE;
          end else begin
            // Release enters and ends at once.
            up_nxt    = 1'b0;
            down_nxt  = 1'b0;
            mode_nxt  = MODE_IDLE;
            timer_nxt = '0;
            done      = 1'b1;
          end
        end else if (!in_range) begin
          status = STAT_RANGE;
        end else begin
          up_nxt    = (cmd == CMD_UP);
          down_nxt  = (cmd != CMD_UP);
          timer_nxt = pulse_ticks;
          mode_nxt  = MODE_PULSE;
        end
      end
      CMD_STOP: begin
        if (mode_r == MODE_AUTO) begin
          up_nxt    = 1'b0;
          down_nxt  = 1'b0;
          mode_nxt  = MODE_IDLE;
          timer_nxt = '0;
          done      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      up_r    <= 1'b0;
      down_r  <= 1'b0;
      timer_r <= '0;
      base_r  <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      up_r    <= up_nxt;
      down_r  <= down_nxt;
      timer_r <= timer_nxt;
      base_r  <= base_nxt;
    end
  end

  assign info.relay_up   = up_nxt;
  assign info.relay_down = down_nxt;
  assign info.mode       = mode_nxt;
  assign info.status     = status;
  assign info.done       = done;

endmodule

FILE: design/winch_weight_mode_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winch_weight_mode_controller_core
// Winch relay controller driven by weight samples, 1 ms ticks and operator
// commands, with an APB-style register port for thresholds and timings.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the in_ stream carries one command in in_tuser (sample,
// tick, manual, auto, hold, release, up, down, stop key or exit) and its
// data in in_tdata. Every request yields exactly one result on the out_
// stream: both relay drives, the latest average, the sample count, the
// mode and a status code.
// The accepting edge loads a request into the input register; once the
// output register is empty or being read, the result from the mode and
// averaging logic is loaded into it and out_tvalid rises. One request is
// taken every cycle while the receiver does not stall; the rate is set by
// the single pass through the averager multiply and the mode compares.
// When the receiver stalls, the output register holds its result and the
// input register keeps the next request, so in_tready falls only when both
// are full. No request is dropped or repeated.
// Reset (rst_n low, synchronous) empties both registers, clears the sum,
// count, average, base weight and timer, sets the mode to idle with both
// relays off and loads the register defaults; pready is always high. The
// user writes registers only while no request is in flight (not checked).
// ----------------------------------------------------------------------------
module winch_weight_mode_controller_core
  import wwm_pkg::*;
#(
  parameter int AVG_COUNT = DefaultAvgCount
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: weight[16:0], sample_ok[17], pulse_ticks[33:18], zero[39:34].
  input  logic [39:0] in_tdata,
  // in_tuser: cmd[3:0].
  input  logic [3:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: relay_up[0], relay_down[1], average[18:2], average_new[19],
  // samples_held[23:20], mode[26:24], status[28:27], mode_done[29],
  // zero[31:30].
  output logic [31:0] out_tdata,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  cfg_t cfg_r;
  logic cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEADBAND:  cfg_r.auto_deadband     <= pwdata[TickW-1:0];
        REG_HOLD_TH:   cfg_r.raise_limit       <= $signed(pwdata[WgtW-1:0]);
        REG_REL_TH:    cfg_r.lower_limit       <= $signed(pwdata[WgtW-1:0]);
        REG_ADJ_TH:    cfg_r.adjust_threshold  <= $signed(pwdata[WgtW-1:0]);
        REG_SETTLE:    cfg_r.settle_ticks      <= pwdata[TickW-1:0];
        REG_ADJ_TICKS: cfg_r.adjust_ticks      <= pwdata[TickW-1:0];
        REG_MIN_PULSE: cfg_r.min_pulse_ticks   <= pwdata[TickW-1:0];
        REG_MAX_PULSE: cfg_r.max_pulse_ticks   <= pwdata[TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Threshold registers read back sign-extended.
  always_comb begin
    unique case (reg_idx)
      REG_DEADBAND:  prdata = 32'(cfg_r.auto_deadband);
      REG_HOLD_TH:   prdata = 32'(cfg_r.raise_limit);
      REG_REL_TH:    prdata = 32'(cfg_r.lower_limit);
      REG_ADJ_TH:    prdata = 32'(cfg_r.adjust_threshold);
      REG_SETTLE:    prdata = 32'(cfg_r.settle_ticks);
      REG_ADJ_TICKS: prdata = 32'(cfg_r.adjust_ticks);
      REG_MIN_PULSE: prdata = 32'(cfg_r.min_pulse_ticks);
      REG_MAX_PULSE: prdata = 32'(cfg_r.max_pulse_ticks);
      default:       prdata = '0;
    endcase
  end

  // Input register: holds one request until the output register can take
  // its result.
  logic                   s1_valid_r;
  logic [CmdW-1:0]        s1_cmd_r;
  logic signed [WgtW-1:0] s1_weight_r;
  logic                   s1_ok_r;
  logic [TickW-1:0]       s1_pulse_r;
  logic                   advance;
  logic                   fire;

  assign advance   = !out_tvalid || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= in_tuser[CmdW-1:0];
      s1_weight_r <= $signed(in_tdata[WgtW-1:0]);
      s1_ok_r     <= in_tdata[WgtW];
      s1_pulse_r  <= in_tdata[WgtW+TickW:WgtW+1];
    end
  end

  // Averaging and mode logic; both update their state when a request fires.
  avg_info_t  avg_info;
  mode_info_t mode_info;

  wwm_avg #(
    .AVG_COUNT (AVG_COUNT)
  ) u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .is_sample (s1_cmd_r == CMD_SAMPLE),
    .sample_ok (s1_ok_r),
    .weight    (s1_weight_r),
    .info      (avg_info)
  );

  wwm_mode u_mode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .cmd         (s1_cmd_r),
    .pulse_ticks (s1_pulse_r),
    .cfg         (cfg_r),
    .avg_info    (avg_info),
    .info        (mode_info)
  );

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {2'b00, mode_info.done, mode_info.status, mode_info.mode,
                     avg_info.held, avg_info.fresh, avg_info.avg,
                     mode_info.relay_down, mode_info.relay_up};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the winch weight mode controller core.
// Requests go in on the in_ stream and every one of them is mirrored by a
// predictor in the bench, which keeps its own copy of the averager, the mode
// state, the relays and the register settings. Each result on the out_ stream
// is compared field by field with the oldest prediction. Directed requests
// cover the codes and corner cases, then random scenarios run under extreme
// and random register settings, with random gaps and stalls on both streams,
// one long receiver hold-off and one stretch with no idling at all.
// ----------------------------------------------------------------------------
module testbench;
  import wwm_pkg::*;

  // Run limit, far above the slowest correct run: about 550 requests, each
  // with a short sender gap and random receiver stalls, one hold-off of
  // HoldOffCycles and the drain pauses.
  localparam int CycleLimit    = 200000;
  localparam int HoldOffCycles = 300;
  localparam int IdlePercent   = 18;
  localparam int AvgN          = DefaultAvgCount;
  localparam int WeightMax     = 50000;

  // Command codes the block leaves unused; it must ignore them.
  localparam logic [CmdW-1:0] CMD_FIRST_UNUSED = 4'd10;
  localparam logic [CmdW-1:0] CMD_LAST_UNUSED  = 4'd15;

  // One result as the block should report it.
  typedef struct packed {
    logic                   relay_up;
    logic                   relay_down;
    logic signed [WgtW-1:0] average;
    logic                   average_new;
    logic [HeldW-1:0]       samples_held;
    logic [ModeW-1:0]       mode;
    logic [StatW-1:0]       status;
    logic                   mode_done;
  } relay_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  winch_weight_mode_controller_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register settings, averager and mode controller.
  // --------------------------------------------------------------------------
  cfg_t                   shadow_cfg;
  logic signed [SumW-1:0] sum_acc;
  logic [HeldW-1:0]       held_count;
  logic signed [WgtW-1:0] avg_w;
  logic signed [WgtW-1:0] base_w;
  logic [ModeW-1:0]       mode_q;
  logic                   up_q;
  logic                   down_q;
  logic [TickW-1:0]       timer_q;

  relay_result_t relay_results_due[$];

  // Bookkeeping shared by the sender, the checker and the test tasks.
  int  requests_sent;
  int  results_checked;
  int  averages_checked;
  int  mismatches;
  int  settings_applied;
  int  cycle_count;
  logic [7:0] modes_seen = '0;
  bit  sender_idles = 1'b1;
  bit  receiver_stalls = 1'b0;
  int  hold_offs_asked = 0;
  int  hold_offs_done = 0;
  int  hold_left = 0;

  function automatic void set_relays(input logic up, input logic down);
    up_q   = up;
    down_q = down;
  endfunction

  // Back to idle with both relays off; tells whether a mode was running.
  function automatic logic enter_idle();
    logic was_busy;
    was_busy = (mode_q != MODE_IDLE);
    set_relays(1'b0, 1'b0);
    mode_q  = MODE_IDLE;
    timer_q = '0;
    return was_busy;
  endfunction

  // Auto mode drives toward the base weight captured at entry, with a
  // deadband on both sides where neither relay is energized.
  function automatic void judge_auto();
    int delta;
    int band;
    delta = int'(avg_w) - int'(base_w);
    band  = int'(shadow_cfg.auto_deadband);
    if (delta > band) begin
      set_relays(1'b1, 1'b0);
    end else if (delta < -band) begin
      set_relays(1'b0, 1'b1);
    end else begin
      set_relays(1'b0, 1'b0);
    end
  endfunction

  // Hold keeps raising while the load is above its threshold, then settles.
  function automatic void judge_raise();
    if (int'(avg_w) > int'(shadow_cfg.raise_limit)) begin
      set_relays(1'b1, 1'b0);
    end else begin
      set_relays(1'b0, 1'b0);
      mode_q  = MODE_SETTLE;
      timer_q = shadow_cfg.settle_ticks;
    end
  endfunction

  // Release keeps lowering while the load is below its threshold.
  function automatic logic judge_release();
    if (int'(avg_w) < int'(shadow_cfg.lower_limit)) begin
      set_relays(1'b0, 1'b1);
      return 1'b0;
    end
    return enter_idle();
  endfunction

  // Applies one request to the predictor and returns the result it causes.
  function automatic relay_result_t advance_winch(input logic [CmdW-1:0] cmd,
                                                  input logic signed [WgtW-1:0] wgt,
                                                  input logic ok,
                                                  input logic [TickW-1:0] req);
    relay_result_t r;
    logic [StatW-1:0] stat;
    logic done;
    logic fresh;
    int sum;
    int avg;
    stat  = STAT_OK;
    done  = 1'b0;
    fresh = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        if (!ok) begin
          stat = STAT_READ_ERR;
        end else begin
          sum = int'(sum_acc) + int'(wgt);
          if (sum > int'(SumMax)) sum = int'(SumMax);
          if (sum < int'(SumMin)) sum = int'(SumMin);
          sum_acc    = sum[SumW-1:0];
          held_count = held_count + 1'b1;
          if (held_count >= AvgN) begin
            // Integer division in SystemVerilog truncates toward zero.
            avg = int'(sum_acc) / AvgN;
            if (avg > 65535) avg = 65535;
            if (avg < -65536) avg = -65536;
            avg_w      = avg[WgtW-1:0];
            sum_acc    = '0;
            held_count = '0;
            fresh      = 1'b1;
            if (mode_q == MODE_AUTO) begin
              judge_auto();
            end else if (mode_q == MODE_RAISE) begin
              judge_raise();
            end else if (mode_q == MODE_RELEASE) begin
              done = judge_release();
            end
          end
        end
      end
      CMD_TICK: begin
        // Only the timed phases count ticks; a zero length ends at the first.
        if (mode_q == MODE_SETTLE || mode_q == MODE_ADJUST || mode_q == MODE_PULSE) begin
          if (timer_q != '0) timer_q = timer_q - 1'b1;
          if (timer_q == '0) begin
            if (mode_q == MODE_SETTLE &&
                int'(avg_w) < int'(shadow_cfg.adjust_threshold)) begin
              set_relays(1'b0, 1'b1);
              mode_q  = MODE_ADJUST;
              timer_q = shadow_cfg.adjust_ticks;
            end else begin
              done = enter_idle();
            end
          end
        end
      end
      CMD_MANUAL, CMD_EXIT: begin
        done = enter_idle();
      end
      CMD_AUTO, CMD_HOLD, CMD_RELEASE, CMD_UP, CMD_DOWN: begin
        if (mode_q != MODE_IDLE) begin
          stat = STAT_BUSY;
        end else if (cmd == CMD_AUTO) begin
          base_w = avg_w;
          mode_q = MODE_AUTO;
          judge_auto();
        end else if (cmd == CMD_HOLD) begin
          mode_q = MODE_RAISE;
          judge_raise();
        end else if (cmd == CMD_RELEASE) begin
          mode_q = MODE_RELEASE;
          done   = judge_release();
        end else if (req < shadow_cfg.min_pulse_ticks || req > shadow_cfg.max_pulse_ticks) begin
          stat = STAT_RANGE;
        end else begin
          set_relays(cmd == CMD_UP, cmd == CMD_DOWN);
          timer_q = req;
          mode_q  = MODE_PULSE;
        end
      end
      CMD_STOP: begin
        if (mode_q == MODE_AUTO) done = enter_idle();
      end
      default: begin
      end
    endcase
    r.relay_up     = up_q;
    r.relay_down   = down_q;
    r.average      = avg_w;
    r.average_new  = fresh;
    r.samples_held = held_count;
    r.mode         = mode_q;
    r.status       = stat;
    r.mode_done    = done;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Offers one request and waits for it to be taken. in_tvalid stays high at
  // the accepting edge, so a following request without a gap keeps it high.
  task automatic offer_request(input logic [CmdW-1:0] cmd, input int wgt,
                               input logic ok, input int ticks);
    if (sender_idles && $urandom_range(99) < IdlePercent) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, ticks[TickW-1:0], ok, wgt[WgtW-1:0]};
    do @(posedge clk); while (!in_tready);
    relay_results_due.push_back(advance_winch(cmd, wgt[WgtW-1:0], ok, ticks[TickW-1:0]));
    requests_sent++;
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (relay_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write: a setup phase, then an access phase that completes at
  // the edge where pready is high.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEADBAND:  shadow_cfg.auto_deadband     = value[TickW-1:0];
      REG_HOLD_TH:   shadow_cfg.raise_limit       = value[WgtW-1:0];
      REG_REL_TH:    shadow_cfg.lower_limit       = value[WgtW-1:0];
      REG_ADJ_TH:    shadow_cfg.adjust_threshold  = value[WgtW-1:0];
      REG_SETTLE:    shadow_cfg.settle_ticks      = value[TickW-1:0];
      REG_ADJ_TICKS: shadow_cfg.adjust_ticks      = value[TickW-1:0];
      REG_MIN_PULSE: shadow_cfg.min_pulse_ticks   = value[TickW-1:0];
      default:       shadow_cfg.max_pulse_ticks   = value[TickW-1:0];
    endcase
  endtask

  task automatic apply_settings(input int deadband, input int hold_th, input int rel_th,
                                input int adj_th, input int settle, input int adj_len,
                                input int min_len, input int max_len);
    write_register(REG_DEADBAND, deadband);
    write_register(REG_HOLD_TH, hold_th);
    write_register(REG_REL_TH, rel_th);
    write_register(REG_ADJ_TH, adj_th);
    write_register(REG_SETTLE, settle);
    write_register(REG_ADJ_TICKS, adj_len);
    write_register(REG_MIN_PULSE, min_len);
    write_register(REG_MAX_PULSE, max_len);
    settings_applied++;
  endtask

  function automatic int clamp_weight(input int w);
    if (w > WeightMax) return WeightMax;
    if (w < -WeightMax) return -WeightMax;
    return w;
  endfunction

  // Aims the next average near one of the decision points, or anywhere.
  function automatic int pick_target();
    int t;
    case ($urandom_range(5))
      0:       t = int'(shadow_cfg.raise_limit);
      1:       t = int'(shadow_cfg.lower_limit);
      2:       t = int'(shadow_cfg.adjust_threshold);
      3:       t = int'(base_w) + int'(shadow_cfg.auto_deadband);
      4:       t = int'(base_w) - int'(shadow_cfg.auto_deadband);
      default: t = int'($urandom_range(2 * WeightMax)) - WeightMax;
    endcase
    return clamp_weight(t + int'($urandom_range(80)) - 40);
  endfunction

  function automatic logic [CmdW-1:0] pick_mode_command();
    case ($urandom_range(4))
      0:       return CMD_AUTO;
      1:       return CMD_HOLD;
      2:       return CMD_RELEASE;
      3:       return CMD_UP;
      default: return CMD_DOWN;
    endcase
  endfunction

  // Mostly a length the block accepts, sometimes any length at all.
  function automatic int pick_pulse_ticks();
    if (shadow_cfg.min_pulse_ticks <= shadow_cfg.max_pulse_ticks &&
        $urandom_range(99) < 85) begin
      return $urandom_range(shadow_cfg.max_pulse_ticks, shadow_cfg.min_pulse_ticks);
    end
    return $urandom_range(65535);
  endfunction

  // Random scenarios: a mode command, then sample groups that complete an
  // average, bursts of ticks, commands that hit a busy mode and some noise,
  // and often an operator command that ends the mode.
  task automatic run_scenarios(input int count);
    int stop_at;
    int target;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      if ($urandom_range(5) != 0)
        offer_request(pick_mode_command(), 0, 1'b1, pick_pulse_ticks());
      repeat ($urandom_range(5, 1)) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            target = pick_target();
            repeat (AvgN)
              offer_request(CMD_SAMPLE, clamp_weight(target + int'($urandom_range(40)) - 20),
                            $urandom_range(99) >= 5, $urandom_range(65535));
          end
          4, 5, 6: begin
            repeat ($urandom_range(6, 1))
              offer_request(CMD_TICK, 0, 1'b0, 0);
          end
          7: offer_request(pick_mode_command(), 0, 1'b1, pick_pulse_ticks());
          default: begin
            offer_request($urandom_range(CMD_LAST_UNUSED),
                          int'($urandom_range(2 * WeightMax)) - WeightMax,
                          $urandom_range(1), $urandom_range(65535));
          end
        endcase
      end
      case ($urandom_range(5))
        0: offer_request(CMD_EXIT, 0, 1'b0, 0);
        1: offer_request(CMD_MANUAL, 0, 1'b0, 0);
        2: offer_request(CMD_STOP, 0, 1'b0, 0);
        default: begin
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: one process stalls the stream at random, runs the long
  // hold-off when a test asks for it, and checks every accepted result.
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_relay_result(input logic [31:0] data);
    relay_result_t want;
    if (relay_results_due.size() == 0) begin
      $error("result with no request waiting: out_tdata %h", data);
      mismatches++;
      return;
    end
    want = relay_results_due.pop_front();
    compare_field("relay_up", want.relay_up, data[0]);
    compare_field("relay_down", want.relay_down, data[1]);
    compare_field("average", int'(want.average), int'($signed(data[18:2])));
    compare_field("average_new", want.average_new, data[19]);
    compare_field("samples_held", want.samples_held, data[23:20]);
    compare_field("mode", want.mode, data[26:24]);
    compare_field("status", want.status, data[28:27]);
    compare_field("mode_done", want.mode_done, data[29]);
    results_checked++;
    if (want.average_new) averages_checked++;
    modes_seen[want.mode] = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (out_tvalid && out_tready) compare_relay_result(out_tdata);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_offs_done != hold_offs_asked) begin
      hold_offs_done++;
      hold_left = HoldOffCycles;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(receiver_stalls && $urandom_range(99) < IdlePercent);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset register values, every command code and the named corner cases.
  task automatic test_commands_at_reset();
    offer_request(CMD_SAMPLE, -WeightMax, 1'b0, 0);           // failed read
    offer_request(CMD_LAST_UNUSED, -1, 1'b1, 65535);          // unused code, all ones
    offer_request(CMD_FIRST_UNUSED, WeightMax, 1'b0, 0);
    offer_request(CMD_TICK, 0, 1'b0, 0);                      // tick while idle
    offer_request(CMD_STOP, 0, 1'b0, 0);                      // stop key while idle
    offer_request(CMD_UP, 0, 1'b1, 99);                       // just below minimum
    offer_request(CMD_DOWN, 0, 1'b1, 3001);                   // just above maximum
    offer_request(CMD_UP, 0, 1'b1, 100);                      // shortest accepted
    offer_request(CMD_AUTO, 0, 1'b1, 0);                      // busy in a pulse
    offer_request(CMD_STOP, 0, 1'b0, 0);                      // stop key ignored
    offer_request(CMD_TICK, 0, 1'b0, 0);
    offer_request(CMD_MANUAL, 0, 1'b0, 0);
    offer_request(CMD_DOWN, 0, 1'b1, 3000);                   // longest accepted
    offer_request(CMD_EXIT, 0, 1'b0, 0);
    // Sum -399993 must average to -39999: truncation toward zero.
    offer_request(CMD_SAMPLE, WeightMax, 1'b1, 0);
    repeat (AvgN - 2) offer_request(CMD_SAMPLE, -WeightMax, 1'b1, 0);
    offer_request(CMD_SAMPLE, -49993, 1'b1, 0);
    offer_request(CMD_RELEASE, 0, 1'b0, 0);                   // lowers at once
    offer_request(CMD_EXIT, 0, 1'b0, 0);
    offer_request(CMD_HOLD, 0, 1'b0, 0);                      // straight to settle
    offer_request(CMD_HOLD, 0, 1'b0, 0);                      // busy
    offer_request(CMD_MANUAL, 0, 1'b0, 0);
    offer_request(CMD_AUTO, 0, 1'b0, 0);                      // base taken here
    offer_request(CMD_STOP, 0, 1'b0, 0);                      // ends auto
    wait_drained();
  endtask

  // Low ends, then high ends: timers 0 and 65535, deadband 0 and WeightMax, thresholds +-WeightMax.
  task automatic test_extreme_settings();
    apply_settings(0, -WeightMax, -WeightMax, -WeightMax, 0, 0, 0, 0);
    run_scenarios(60);
    wait_drained();
    apply_settings(WeightMax, WeightMax, WeightMax, WeightMax, 65535, 65535, 65535, 65535);
    run_scenarios(60);
    wait_drained();
  endtask

  // Random thresholds near zero and short timers, so that hold runs through
  // settle and adjust and the timed pulses end inside a scenario.
  task automatic test_random_settings();
    repeat (3) begin
      apply_settings($urandom_range(1500), int'($urandom_range(6000)) - 3000,
                     int'($urandom_range(6000)) - 3000, int'($urandom_range(6000)) - 3000,
                     $urandom_range(4), $urandom_range(4), $urandom_range(3),
                     $urandom_range(12));
      run_scenarios(70);
      wait_drained();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // both internal registers fill and in_tready has to fall.
  task automatic test_output_backpressure();
    sender_idles = 1'b0;
    hold_offs_asked <= hold_offs_asked + 1;
    run_scenarios(40);
    wait_drained();
    sender_idles = 1'b1;
  endtask

  // A stretch with no idling on either side: one request every cycle.
  task automatic test_back_to_back();
    sender_idles = 1'b0;
    receiver_stalls <= 1'b0;
    run_scenarios(80);
    wait_drained();
    sender_idles = 1'b1;
    receiver_stalls <= 1'b1;
  endtask

  initial begin
    shadow_cfg       = CfgReset;
    sum_acc          = '0;
    held_count       = '0;
    avg_w            = '0;
    base_w           = '0;
    mode_q           = MODE_IDLE;
    up_q             = 1'b0;
    down_q           = 1'b0;
    timer_q          = '0;
    requests_sent    = 0;
    results_checked  = 0;
    averages_checked = 0;
    mismatches       = 0;
    settings_applied = 1;
    cycle_count      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    receiver_stalls <= 1'b1;
    @(posedge clk);

    test_commands_at_reset();
    test_extreme_settings();
    test_random_settings();
    test_output_backpressure();
    test_back_to_back();

    // Give any stray result time to show up.
    repeat (10) @(posedge clk);
    $display("Run covered %0d requests under %0d register settings, %0d results checked.",
             requests_sent, settings_applied, results_checked);
    $display("It completed %0d averages and visited modes %b (bit per mode code).",
             averages_checked, modes_seen);
    if (mismatches == 0 && relay_results_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
